@@ hdl/tri_heron_pkg.sv @@
package tri_heron_pkg;

    // Default width of one side length.
    localparam int SIDE_BITS_DEF = 12;

    // Width of the area result port, fixed for all supported side widths.
    localparam int AREA_BITS = 25;

endpackage

@@ hdl/triangle_check_heron_area.sv @@
// Throughput: one word per cycle; busy is always low.
// The pipeline has three arithmetic stages, then one product stage, then one root bit per stage.
// Reset (rst_n low, asynchronous) clears the valid bits; words in flight are dropped.
// The receiver cannot stall: each result is shown on the output ports for one cycle with done.
module triangle_check_heron_area
    import tri_heron_pkg::*;
#(
    parameter int SIDE_BITS = SIDE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [SIDE_BITS-1:0] side_a,
    input  logic [SIDE_BITS-1:0] side_b,
    input  logic [SIDE_BITS-1:0] side_c,
    output logic                 done,
    output logic                 is_valid,
    output logic [AREA_BITS-1:0] area_times_four
);

    // Widths of the intermediate values.
    localparam int PER_BITS  = SIDE_BITS + 2;
    localparam int FAC_BITS  = SIDE_BITS + 1;
    localparam int M1_BITS   = PER_BITS + FAC_BITS;
    localparam int M2_BITS   = 2 * FAC_BITS;
    localparam int HALF_BITS = FAC_BITS;
    localparam int PP_BITS   = M1_BITS + HALF_BITS;
    localparam int SUM_BITS  = PP_BITS + HALF_BITS;
    localparam int ROOT_BITS = 2 * SIDE_BITS + 1;
    localparam int RAD_BITS  = 2 * ROOT_BITS;
    localparam int REM_BITS  = ROOT_BITS + 1;
    localparam int SH_BITS   = ROOT_BITS + 3;

    // Stage 1: perimeter, the three factors and the validity test.
    logic                 vld1_reg;
    logic                 ok1_reg;
    logic [PER_BITS-1:0]  per_reg;
    logic [FAC_BITS-1:0]  x_reg;
    logic [FAC_BITS-1:0]  y_reg;
    logic [FAC_BITS-1:0]  z_reg;
    logic                 ok1_next;
    logic [PER_BITS-1:0]  per_next;
    logic [FAC_BITS-1:0]  x_next;
    logic [FAC_BITS-1:0]  y_next;
    logic [FAC_BITS-1:0]  z_next;
    logic [SIDE_BITS-1:0] max_side;
    logic [PER_BITS-1:0]  a_ext;
    logic [PER_BITS-1:0]  b_ext;
    logic [PER_BITS-1:0]  c_ext;

    // Stage 2: two partial products.
    logic                 vld2_reg;
    logic                 ok2_reg;
    logic [M1_BITS-1:0]   m1_reg;
    logic [M2_BITS-1:0]   m2_reg;

    // Stage 3: the final product split across the halves of the second operand.
    logic                 vld3_reg;
    logic                 ok3_reg;
    logic [PP_BITS-1:0]   plo_reg;
    logic [PP_BITS-1:0]   phi_reg;

    // Stage 4 and the root stages.
    logic                 vld_reg  [0:ROOT_BITS];
    logic                 ok_reg   [0:ROOT_BITS];
    logic [RAD_BITS-1:0]  rad_reg  [0:ROOT_BITS];
    logic [REM_BITS-1:0]  rem_reg  [0:ROOT_BITS];
    logic [ROOT_BITS-1:0] root_reg [0:ROOT_BITS];
    logic [SUM_BITS-1:0]  prod_sum;

    // Every cycle can take a word.
    assign busy = 1'b0;

    // Sums and differences of the sides, and the longest side.
    always_comb
    begin
        a_ext = PER_BITS'(side_a);
        b_ext = PER_BITS'(side_b);
        c_ext = PER_BITS'(side_c);
        max_side = side_a;
        if (side_b > max_side)
        begin
            max_side = side_b;
        end
        if (side_c > max_side)
        begin
            max_side = side_c;
        end
        per_next = a_ext + b_ext + c_ext;
        ok1_next = ({1'b0, max_side, 1'b0} < per_next);
        x_next   = FAC_BITS'(b_ext + c_ext - a_ext);
        y_next   = FAC_BITS'(a_ext + c_ext - b_ext);
        z_next   = FAC_BITS'(a_ext + b_ext - c_ext);
    end

    // Valid bits of the front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= start && !busy;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    // Data of the front stages.
    always_ff @(posedge clk)
    begin
        ok1_reg <= ok1_next;
        per_reg <= per_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;

        ok2_reg <= ok1_reg;
        m1_reg  <= M1_BITS'(per_reg * x_reg);
        m2_reg  <= M2_BITS'(y_reg * z_reg);

        ok3_reg <= ok2_reg;
        plo_reg <= PP_BITS'(m1_reg * m2_reg[HALF_BITS-1:0]);
        phi_reg <= PP_BITS'(m1_reg * m2_reg[M2_BITS-1:HALF_BITS]);
    end

    // Recombine the halves into the full product.
    assign prod_sum = SUM_BITS'(plo_reg) + {phi_reg, {HALF_BITS{1'b0}}};

    // Stage 4: radicand, zero for a rejected triangle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= vld3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg[0]   <= ok3_reg;
        rad_reg[0]  <= ok3_reg ? RAD_BITS'(prod_sum) : '0;
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
    end

    // Root stages: each brings down two radicand bits and settles one root bit.
    for (genvar k = 0; k < ROOT_BITS; k++)
    begin : g_root
        logic [SH_BITS-1:0]   rem_sh;
        logic [SH_BITS-1:0]   trial;
        logic                 fits;
        logic [REM_BITS-1:0]  rem_next;
        logic [ROOT_BITS-1:0] root_next;
        logic [RAD_BITS-1:0]  rad_next;

        always_comb
        begin
            rem_sh    = {rem_reg[k], rad_reg[k][RAD_BITS-1:RAD_BITS-2]};
            trial     = SH_BITS'({root_reg[k], 2'b01});
            fits      = (rem_sh >= trial);
            rem_next  = fits ? REM_BITS'(rem_sh - trial) : REM_BITS'(rem_sh);
            root_next = {root_reg[k][ROOT_BITS-2:0], fits};
            rad_next  = {rad_reg[k][RAD_BITS-3:0], 2'b00};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            ok_reg[k+1]   <= ok_reg[k];
            rad_reg[k+1]  <= rad_next;
            rem_reg[k+1]  <= rem_next;
            root_reg[k+1] <= root_next;
        end
    end

    // Result word from the last root stage.
    assign done            = vld_reg[ROOT_BITS];
    assign is_valid        = ok_reg[ROOT_BITS];
    assign area_times_four = AREA_BITS'(root_reg[ROOT_BITS]);

endmodule

@@ verif/triangle_area_checker.sv @@
// Watches the input and result channels of the triangle area block, predicts
// each result from the accepted word, and compares in arrival order.
module triangle_area_checker
    import tri_heron_pkg::*;
#(
    parameter int SIDE_BITS = SIDE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic [SIDE_BITS-1:0] side_a,
    input  logic [SIDE_BITS-1:0] side_b,
    input  logic [SIDE_BITS-1:0] side_c,
    input  logic                 done,
    input  logic                 is_valid,
    input  logic [AREA_BITS-1:0] area_times_four,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic                 valid;
        logic [AREA_BITS-1:0] area;
    } tri_area_t;

    tri_area_t area_queue[$];

    // Classifies the triangle and returns the floor of four times its area.
    function automatic tri_area_t heron_area_x4(input logic [SIDE_BITS-1:0] sa,
                                                input logic [SIDE_BITS-1:0] sb,
                                                input logic [SIDE_BITS-1:0] sc);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] per;
        logic [63:0] longest;
        logic [63:0] prod;
        logic [63:0] root;
        logic [63:0] trial;
        tri_area_t   res;
        a = 64'(sa);
        b = 64'(sb);
        c = 64'(sc);
        per = a + b + c;
        longest = a;
        if (b > longest)
        begin
            longest = b;
        end
        if (c > longest)
        begin
            longest = c;
        end
        res.valid = 1'b0;
        res.area = '0;
        // Degenerate, collinear and all-zero sides fall out here.
        if (2 * longest < per)
        begin
            prod = per * (b + c - a) * (a + c - b) * (a + b - c);
            // Build the root one bit at a time from the top, keeping root^2 <= prod.
            root = 0;
            for (int i = 31; i >= 0; i--)
            begin
                trial = root | (64'd1 << i);
                if (trial * trial <= prod)
                begin
                    root = trial;
                end
            end
            res.valid = 1'b1;
            res.area = root[AREA_BITS-1:0];
        end
        return res;
    endfunction

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    // Results are compared before the word of the same edge is queued,
    // since a result can never belong to a word accepted at that edge.
    always @(posedge clk)
    begin
        tri_area_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (area_queue.size() == 0)
                begin
                    $error("result word with no expected result: is_valid %0d area %0d",
                           is_valid, area_times_four);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = area_queue.pop_front();
                    if (is_valid !== want.valid)
                    begin
                        $error("is_valid: expected %0d, actual %0d", want.valid, is_valid);
                        fail_count = fail_count + 1;
                    end
                    if (area_times_four !== want.area)
                    begin
                        $error("area_times_four: expected %0d, actual %0d",
                               want.area, area_times_four);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (start && !busy)
            begin
                area_queue.push_back(heron_area_x4(side_a, side_b, side_c));
            end
        end
        pending = area_queue.size();
    end

endmodule

@@ verif/tb_top.sv @@
// Drives triangle words into the block and gives the verdict; all checking
// happens in the checker instance.
module tb_top;
    import tri_heron_pkg::*;

    localparam int SIDE_BITS = SIDE_BITS_DEF;
    localparam int SIDE_MAX = (1 << SIDE_BITS) - 1;
    localparam int RANDOM_WORDS = 600;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 2 * SIDE_BITS + 20;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [SIDE_BITS-1:0] side_a;
    logic [SIDE_BITS-1:0] side_b;
    logic [SIDE_BITS-1:0] side_c;
    logic                 done;
    logic                 is_valid;
    logic [AREA_BITS-1:0] area_times_four;
    int                   fail_count;
    int                   pending;
    int                   cycle_count;
    bit                   no_idle;

    triangle_check_heron_area #(
        .SIDE_BITS(SIDE_BITS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .side_a(side_a),
        .side_b(side_b),
        .side_c(side_c),
        .done(done),
        .is_valid(is_valid),
        .area_times_four(area_times_four)
    );

    triangle_area_checker #(
        .SIDE_BITS(SIDE_BITS)
    ) i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .side_a(side_a),
        .side_b(side_b),
        .side_c(side_c),
        .done(done),
        .is_valid(is_valid),
        .area_times_four(area_times_four),
        .fail_count(fail_count),
        .pending(pending)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Cycle watchdog.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count = cycle_count + 1;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Sends one word after a random gap, or none while no_idle is set, and returns once it has been accepted.
    task automatic send_word(input int a, input int b, input int c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        for (int g = 0; g < gap; g++)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        side_a <= SIDE_BITS'(a);
        side_b <= SIDE_BITS'(b);
        side_c <= SIDE_BITS'(c);
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    // Sends the three sides in one of their three rotations, picked at random.
    task automatic send_rotated(input int a, input int b, input int c);
        case ($urandom_range(0, 2))
            0: send_word(a, b, c);
            1: send_word(b, c, a);
            default: send_word(c, a, b);
        endcase
    endtask

    // Builds one random word: mostly proper triangles, otherwise degenerate ones,
    // raw noise or tiny sides.
    task automatic send_random_word();
        int kind;
        int s1;
        int s2;
        int lo;
        int hi;
        kind = $urandom_range(0, 99);
        s1 = $urandom_range(1, SIDE_MAX);
        s2 = $urandom_range(1, SIDE_MAX);
        lo = (s1 > s2 ? s1 - s2 : s2 - s1) + 1;
        hi = s1 + s2 - 1;
        if (hi > SIDE_MAX)
        begin
            hi = SIDE_MAX;
        end
        if (kind < 55)
        begin
            send_rotated(s1, s2, $urandom_range(lo, hi));
        end
        else if (kind < 70)
        begin
            // Collinear: third side equals the sum or the difference.
            if (s1 + s2 <= SIDE_MAX && $urandom_range(0, 1))
            begin
                send_rotated(s1, s2, s1 + s2);
            end
            else
            begin
                send_rotated(s1, s2, lo - 1);
            end
        end
        else if (kind < 85)
        begin
            send_word($urandom_range(0, SIDE_MAX), $urandom_range(0, SIDE_MAX),
                      $urandom_range(0, SIDE_MAX));
        end
        else
        begin
            send_word($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15));
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        side_a = '0;
        side_b = '0;
        side_c = '0;
        no_idle = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed words: zero sides, extremes, collinear and barely valid cases.
        send_word(0, 0, 0);
        send_word(SIDE_MAX, 0, 0);
        send_word(0, SIDE_MAX, 0);
        send_word(0, 0, SIDE_MAX);
        send_word(SIDE_MAX, SIDE_MAX, SIDE_MAX);
        send_word(1, 1, 1);
        send_word(3, 4, 5);
        send_word(5, 3, 4);
        send_word(1, 2, 3);
        send_word(3, 1, 2);
        send_word(2, 3, 1);
        send_word(SIDE_MAX, SIDE_MAX, 0);
        send_word(SIDE_MAX, SIDE_MAX, 1);
        send_word(1, SIDE_MAX, SIDE_MAX);
        send_word(SIDE_MAX, 1, SIDE_MAX);
        send_word(2048, 2048, SIDE_MAX);
        send_word(2048, 2047, SIDE_MAX);
        send_word(SIDE_MAX, 2048, 2047);
        send_word(2730, 2730, 2730);
        send_word(1, 1, 2);
        send_word(2, 2, 3);
        send_word(SIDE_MAX, 1, 1);

        // Random words, with stretches of back-to-back traffic.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 40 == 0)
            begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            send_random_word();
        end
        @(negedge clk);
        start <= 1'b0;

        // Drain the pipeline, then wait out DRAIN_CYCLES for stray results.
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/tri_heron_pkg.sv
hdl/triangle_check_heron_area.sv
verif/triangle_area_checker.sv
verif/tb_top.sv
